// File: hdl/ppob_pkg.sv
package ppob_pkg;

	localparam int DEF_MAX_TILE_W = 1024;
	localparam int DEF_MAX_TILE_H = 1024;

	// One bitmap word holds WORD_BITS pixels; WBL is its log2.
	localparam int WORD_BITS = 64;
	localparam int WBL       = $clog2(WORD_BITS);

	localparam int CNT_W   = 48;
	localparam int COORD_W = 32;
	localparam int OFS_W   = 24;
	localparam int TDIM_W  = 11;
	localparam int LOC_W   = 10;
	localparam int WIDX_W  = 14;

	localparam logic signed [COORD_W-1:0] RST_CENTER_X  = 32'sd0;
	localparam logic signed [COORD_W-1:0] RST_CENTER_Y  = 32'sd0;
	localparam logic signed [COORD_W-1:0] RST_COEFF_COS = 32'sd6553600;
	localparam logic signed [COORD_W-1:0] RST_COEFF_SIN = 32'sd0;
	localparam logic signed [OFS_W-1:0]   RST_OFFSET_X  = 24'sd2048;
	localparam logic signed [OFS_W-1:0]   RST_OFFSET_Y  = 24'sd2048;
	localparam logic [TDIM_W-1:0]         RST_TILE_W    = 11'd1024;
	localparam logic [TDIM_W-1:0]         RST_TILE_H    = 11'd1024;

	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_COEFF_COS = 3'd2,
		REG_COEFF_SIN = 3'd3,
		REG_OFFSET_X  = 3'd4,
		REG_OFFSET_Y  = 3'd5,
		REG_TILE_W    = 3'd6,
		REG_TILE_H    = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_PLOT = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_PLOTTED   = 2'd0,
		ST_CLIPPED   = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_READ      = 2'd3
	} status_t;

	typedef struct packed {
		op_t                        op;
		logic signed [COORD_W-1:0]  point_x;
		logic signed [COORD_W-1:0]  point_y;
		logic [WIDX_W-1:0]          word_index;
	} in_item_t;

	typedef struct packed {
		status_t                status;
		logic [LOC_W-1:0]       local_x;
		logic [LOC_W-1:0]       local_y;
		logic [WORD_BITS-1:0]   read_word;
		logic [CNT_W-1:0]       plotted_total;
		logic [CNT_W-1:0]       clipped_total;
		logic [CNT_W-1:0]       deduped_total;
	} out_item_t;

	typedef struct packed {
		reg_idx_t               reg_index;
		logic [COORD_W-1:0]     wdata;
	} cfg_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clear;
		logic       load;
		logic       mul;
		logic [1:0] mul_sel;
		logic       acc;
		logic [1:0] acc_sel;
		logic       pix;
		logic       rd;
		logic       finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic out_free;
	} sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

endpackage

// File: hdl/ppob_stream_if.sv
interface ppob_req_if import ppob_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ppob_rsp_if import ppob_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ppob_cfg_if import ppob_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ppob_ram.sv
module ppob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/ppob_ctrl.sv
module ppob_ctrl import ppob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  op_t  req_op,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_MUL    = 6'b000100,
		S_PIX    = 6'b001000,
		S_RD     = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	localparam logic [2:0] MUL_LAST = 3'd4;

	state_t     state_q, state_d;
	logic [2:0] step_q;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_op == OP_READ) ? S_RD : S_MUL;
				end
			end
			S_MUL: begin
				// Step n starts product n and folds product n-1 into its accumulator.
				cmd.mul     = (step_q != MUL_LAST);
				cmd.mul_sel = step_q[1:0];
				cmd.acc     = (step_q != 3'd0);
				cmd.acc_sel = 2'(step_q - 3'd1);
				if (step_q == MUL_LAST) begin
					state_d = S_PIX;
				end
			end
			S_PIX: begin
				cmd.pix = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			step_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL && step_q != MUL_LAST) begin
				step_q <= step_q + 3'd1;
			end else begin
				step_q <= 3'd0;
			end
		end
	end

endmodule

// File: hdl/ppob_dp.sv
module ppob_dp import ppob_pkg::*; #(
	parameter int MAX_TILE_W = DEF_MAX_TILE_W,
	parameter int MAX_TILE_H = DEF_MAX_TILE_H
) (
	input  logic         clk,
	input  logic         arst_n,
	input  in_item_t     req_data,
	ppob_cfg_if.sink     cfg,
	ppob_rsp_if.source   rsp,
	input  cmd_t         cmd,
	output sts_t         sts
);

	localparam int BITMAP_WORDS = (MAX_TILE_W * MAX_TILE_H + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int DW    = COORD_W + 1;
	localparam int PW    = DW + COORD_W;
	localparam int ACCW  = PW + 1;
	localparam int FRAC  = 2 * (COORD_W / 2);
	localparam int LW    = ACCW - FRAC + 1;
	localparam int PIXW  = 2 * TDIM_W + 1;
	localparam int WAW   = PIXW - WBL;
	localparam int XPW   = (AW > WAW) ? AW : WAW;
	localparam int XIW   = (AW > WIDX_W) ? AW : WIDX_W;

	// Configuration registers.
	logic signed [COORD_W-1:0] center_x_q, center_y_q, coeff_cos_q, coeff_sin_q;
	logic signed [OFS_W-1:0]   offset_x_q, offset_y_q;
	logic [TDIM_W-1:0]         tile_w_q, tile_h_q;
	logic [TDIM_W-1:0]         w_c, h_c;

	// Item working registers.
	op_t                 op_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic [AW-1:0]       rd_addr_q;
	logic                rd_ok_q;
	logic signed [PW-1:0] prod_q;
	logic signed [ACCW-1:0] acc_x_q, acc_y_q;
	logic [TDIM_W-1:0]   lx_q, ly_q;
	logic                clip_q;
	logic [AW-1:0]       waddr_q;
	logic [WBL-1:0]      bofs_q;

	logic [AW-1:0]       clr_addr_q;
	logic [CNT_W-1:0]    plotted_q, clipped_q, deduped_q;
	logic [CNT_W-1:0]    plotted_d, clipped_d, deduped_d;
	logic                out_valid_q;
	out_item_t           out_q, out_d;

	logic signed [DW-1:0]      mul_a;
	logic signed [COORD_W-1:0] mul_b;
	logic signed [LW-1:0]      lx_full, ly_full;
	logic                      clip_c;
	logic [PIXW-1:0]           pix;
	logic [XPW-1:0]            pix_word;
	logic [XIW-1:0]            widx_ext;

	logic                 ram_we, ram_re, hit;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	assign cfg.ready = 1'b1;

	assign w_c = (32'(tile_w_q) > 32'(MAX_TILE_W)) ? TDIM_W'(MAX_TILE_W) : tile_w_q;
	assign h_c = (32'(tile_h_q) > 32'(MAX_TILE_H)) ? TDIM_W'(MAX_TILE_H) : tile_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= RST_CENTER_X;
			center_y_q  <= RST_CENTER_Y;
			coeff_cos_q <= RST_COEFF_COS;
			coeff_sin_q <= RST_COEFF_SIN;
			offset_x_q  <= RST_OFFSET_X;
			offset_y_q  <= RST_OFFSET_Y;
			tile_w_q    <= RST_TILE_W;
			tile_h_q    <= RST_TILE_H;
		end else if (cfg.valid) begin
			unique case (cfg.payload.reg_index)
				REG_CENTER_X:  center_x_q  <= cfg.payload.wdata;
				REG_CENTER_Y:  center_y_q  <= cfg.payload.wdata;
				REG_COEFF_COS: coeff_cos_q <= cfg.payload.wdata;
				REG_COEFF_SIN: coeff_sin_q <= cfg.payload.wdata;
				REG_OFFSET_X:  offset_x_q  <= cfg.payload.wdata[OFS_W-1:0];
				REG_OFFSET_Y:  offset_y_q  <= cfg.payload.wdata[OFS_W-1:0];
				REG_TILE_W:    tile_w_q    <= cfg.payload.wdata[TDIM_W-1:0];
				REG_TILE_H:    tile_h_q    <= cfg.payload.wdata[TDIM_W-1:0];
			endcase
		end
	end

	// One shared multiplier: dx*cos, dy*sin, dx*sin, dy*cos in turn.
	always_comb begin
		mul_a = dx_q;
		mul_b = coeff_cos_q;
		case (cmd.mul_sel)
			2'd0: begin mul_a = dx_q; mul_b = coeff_cos_q; end
			2'd1: begin mul_a = dy_q; mul_b = coeff_sin_q; end
			2'd2: begin mul_a = dx_q; mul_b = coeff_sin_q; end
			default: begin mul_a = dy_q; mul_b = coeff_cos_q; end
		endcase
	end

	// Floor of the Q34.32 value is an arithmetic shift of the exact sum.
	assign lx_full = LW'(offset_x_q) + LW'($signed(acc_x_q[ACCW-1:FRAC]));
	assign ly_full = LW'(offset_y_q) + LW'($signed(acc_y_q[ACCW-1:FRAC]));
	assign clip_c  = lx_full[LW-1] || ly_full[LW-1]
		|| (lx_full[LW-2:0] >= (LW-1)'(w_c)) || (ly_full[LW-2:0] >= (LW-1)'(h_c));

	assign pix      = PIXW'(ly_q) * PIXW'(w_c) + PIXW'(lx_q);
	assign pix_word = XPW'(pix[PIXW-1:WBL]);
	assign widx_ext = XIW'(req_data.word_index);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req_data.op;
			dx_q      <= DW'(req_data.point_x) - DW'(center_x_q);
			dy_q      <= DW'(req_data.point_y) - DW'(center_y_q);
			rd_addr_q <= widx_ext[AW-1:0];
			rd_ok_q   <= (32'(req_data.word_index) < 32'(BITMAP_WORDS));
		end
		if (cmd.mul) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc) begin
			case (cmd.acc_sel)
				2'd0: acc_x_q <= ACCW'(prod_q);
				2'd1: acc_x_q <= acc_x_q - ACCW'(prod_q);
				2'd2: acc_y_q <= -ACCW'(prod_q);
				default: acc_y_q <= acc_y_q - ACCW'(prod_q);
			endcase
		end
		if (cmd.pix) begin
			lx_q   <= lx_full[TDIM_W-1:0];
			ly_q   <= ly_full[TDIM_W-1:0];
			clip_q <= clip_c;
		end
		if (cmd.rd) begin
			waddr_q <= pix_word[AW-1:0];
			bofs_q  <= pix[WBL-1:0];
		end
	end

	assign ram_re    = cmd.rd;
	assign ram_raddr = (op_q == OP_READ) ? rd_addr_q : pix_word[AW-1:0];
	assign hit       = ram_rdata[bofs_q];

	always_comb begin
		out_d     = '0;
		plotted_d = plotted_q;
		clipped_d = clipped_q;
		deduped_d = deduped_q;
		ram_we    = cmd.clear;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		if (op_q == OP_READ) begin
			out_d.status    = ST_READ;
			out_d.read_word = rd_ok_q ? ram_rdata : '0;
		end else if (clip_q) begin
			out_d.status = ST_CLIPPED;
			clipped_d    = sat_inc(clipped_q);
		end else begin
			out_d.local_x = lx_q[LOC_W-1:0];
			out_d.local_y = ly_q[LOC_W-1:0];
			if (hit) begin
				out_d.status = ST_DUPLICATE;
				deduped_d    = sat_inc(deduped_q);
			end else begin
				out_d.status = ST_PLOTTED;
				plotted_d    = sat_inc(plotted_q);
				if (cmd.finish) begin
					ram_we    = 1'b1;
					ram_waddr = waddr_q;
					ram_wdata = ram_rdata | (WORD_BITS'(1) << bofs_q);
				end
			end
		end
		out_d.plotted_total = plotted_d;
		out_d.clipped_total = clipped_d;
		out_d.deduped_total = deduped_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			plotted_q   <= '0;
			clipped_q   <= '0;
			deduped_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.finish) begin
				plotted_q   <= plotted_d;
				clipped_q   <= clipped_d;
				deduped_q   <= deduped_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.payload  = out_q;
	assign sts.out_free = !out_valid_q || rsp.ready;
	assign sts.clr_last = (clr_addr_q == AW'(BITMAP_WORDS - 1));

	ppob_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(BITMAP_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	a_cnt_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(plotted_q >= $past(plotted_q)) && (clipped_q >= $past(clipped_q))
		&& (deduped_q >= $past(deduped_q)))
		else $error("statistics counter decreased");

	a_one_cnt_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({plotted_q != $past(plotted_q), clipped_q != $past(clipped_q),
			deduped_q != $past(deduped_q)}) <= 1)
		else $error("more than one counter moved in one transaction");

	a_pixel_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && op_q == OP_PLOT && !clip_q) |-> (lx_q < w_c) && (ly_q < h_c))
		else $error("unclipped pixel lies outside the tile");

	a_write_is_plot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && ram_we) |=> (out_q.status == ST_PLOTTED))
		else $error("bitmap written for a transaction that is not a new pixel");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result appeared without a finished transaction");

endmodule

// File: hdl/point_projection_occupancy_bitmap.sv
// Plot transaction: four multiply steps, a pixel step and a bitmap read after acceptance.
// Read transaction: a bitmap read after acceptance. Each then registers its result once the
// output register is free, and only then is the next accepted. The plot time is set by one
// 33x32 multiplier taking four passes plus the bitmap read. A finished result may wait in the
// output register while the next transaction is accepted. After reset the bitmap RAM is
// cleared one word a cycle; no transaction is accepted then, configuration writes are taken.
module point_projection_occupancy_bitmap import ppob_pkg::*; #(
	parameter int MAX_TILE_W = DEF_MAX_TILE_W,
	parameter int MAX_TILE_H = DEF_MAX_TILE_H
) (
	input  logic        clk,
	input  logic        arst_n,
	ppob_req_if.sink    req,
	ppob_rsp_if.source  rsp,
	ppob_cfg_if.sink    cfg
);

	cmd_t cmd;
	sts_t sts;
	logic req_ready;

	assign req.ready = req_ready;

	ppob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_op    (req.payload.op),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ppob_dp #(
		.MAX_TILE_W(MAX_TILE_W),
		.MAX_TILE_H(MAX_TILE_H)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.payload),
		.cfg      (cfg),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// File: test/tb_top.sv
module tb_top import ppob_pkg::*; ;

	localparam int MAP_WORDS      = DEF_MAX_TILE_W * DEF_MAX_TILE_H / WORD_BITS;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 80000;

	typedef enum {EV_NONE, EV_HOLD, EV_DRAIN} phase_event_t;
	typedef enum {RX_ALWAYS, RX_MOSTLY, RX_COMB, RX_SPARSE} stall_mode_t;

	class occupancy_scoreboard;
		longint cen_x, cen_y, k_cos, k_sin, off_x, off_y;
		bit [TDIM_W-1:0] tile_w, tile_h;
		bit [WORD_BITS-1:0] occ_map [MAP_WORDS];
		bit [CNT_W-1:0] n_plotted, n_clipped, n_deduped;
		out_item_t pending_results[$];
		logic [WIDX_W-1:0] touched[$];
		int mismatches;

		function new();
			cen_x  = longint'(RST_CENTER_X);
			cen_y  = longint'(RST_CENTER_Y);
			k_cos  = longint'(RST_COEFF_COS);
			k_sin  = longint'(RST_COEFF_SIN);
			off_x  = longint'(RST_OFFSET_X);
			off_y  = longint'(RST_OFFSET_Y);
			tile_w = RST_TILE_W;
			tile_h = RST_TILE_H;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_CENTER_X:  cen_x = longint'($signed(d));
				REG_CENTER_Y:  cen_y = longint'($signed(d));
				REG_COEFF_COS: k_cos = longint'($signed(d));
				REG_COEFF_SIN: k_sin = longint'($signed(d));
				REG_OFFSET_X:  off_x = longint'($signed(d[OFS_W-1:0]));
				REG_OFFSET_Y:  off_y = longint'($signed(d[OFS_W-1:0]));
				REG_TILE_W:    tile_w = d[TDIM_W-1:0];
				REG_TILE_H:    tile_h = d[TDIM_W-1:0];
			endcase
		endfunction

		// Products stay below 2^63 in magnitude; one extra bit holds their difference.
		function logic signed [64:0] widen(longint v);
			return {v[63], v};
		endfunction

		function void note_request(in_item_t it);
			out_item_t r;
			longint dx, dy, lx, ly, w, h, pix;
			logic signed [64:0] num_x, num_y;
			bit [WORD_BITS-1:0] m;
			int wi;
			r = '0;
			if (it.op == OP_READ) begin
				r.status = ST_READ;
				r.read_word = occ_map[it.word_index];
			end else begin
				dx = longint'($signed(it.point_x)) - cen_x;
				dy = longint'($signed(it.point_y)) - cen_y;
				num_x = widen(dx * k_cos) - widen(dy * k_sin);
				num_y = -widen(dx * k_sin) - widen(dy * k_cos);
				// Arithmetic shift gives floor, not truncation toward zero.
				lx = off_x + longint'(num_x >>> 32);
				ly = off_y + longint'(num_y >>> 32);
				w = (tile_w > DEF_MAX_TILE_W) ? DEF_MAX_TILE_W : tile_w;
				h = (tile_h > DEF_MAX_TILE_H) ? DEF_MAX_TILE_H : tile_h;
				if (lx < 0 || ly < 0 || lx >= w || ly >= h) begin
					r.status = ST_CLIPPED;
					if (n_clipped != '1)
						n_clipped++;
				end else begin
					pix = ly * w + lx;
					wi = int'(pix / WORD_BITS);
					m = 1 << (pix % WORD_BITS);
					r.local_x = lx[LOC_W-1:0];
					r.local_y = ly[LOC_W-1:0];
					if ((occ_map[wi] & m) != 0) begin
						r.status = ST_DUPLICATE;
						if (n_deduped != '1)
							n_deduped++;
					end else begin
						occ_map[wi] |= m;
						r.status = ST_PLOTTED;
						if (n_plotted != '1)
							n_plotted++;
						touched.push_back(WIDX_W'(wi));
						if (touched.size() > 64)
							void'(touched.pop_front());
					end
				end
			end
			r.plotted_total = n_plotted;
			r.clipped_total = n_clipped;
			r.deduped_total = n_deduped;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_response(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding, status %0d", got.status);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("local_x", want.local_x, got.local_x);
			compare_field("local_y", want.local_y, got.local_y);
			compare_field("read_word", want.read_word, got.read_word);
			compare_field("plotted_total", want.plotted_total, got.plotted_total);
			compare_field("clipped_total", want.clipped_total, got.clipped_total);
			compare_field("deduped_total", want.deduped_total, got.deduped_total);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ppob_req_if req();
	ppob_rsp_if rsp();
	ppob_cfg_if cfg();

	point_projection_occupancy_bitmap dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	always #1 clk = ~clk;

	occupancy_scoreboard sb = new();

	bit sender_gaps = 1'b1;
	int unsigned burst_left = 0;
	bit rsp_hold_pending = 1'b0;
	int unsigned quiet_cycles = 0;
	longint cur_cx, cur_cy, cur_kc, cur_ks, cur_w, cur_h;
	in_item_t recent_pts[$];

	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_response(rsp.payload);
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Result side: stall pattern re-picked periodically from four modes; a long hold on request.
	initial begin
		int unsigned tick;
		stall_mode_t mode;
		rsp.ready = 1'b0;
		tick = 0;
		mode = RX_ALWAYS;
		forever begin
			@(posedge clk);
			if (rsp_hold_pending) begin
				rsp_hold_pending = 1'b0;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				tick++;
				if (tick % 48 == 0)
					mode = stall_mode_t'($urandom_range(0, 3));
				case (mode)
					RX_ALWAYS: rsp.ready <= 1'b1;
					RX_MOSTLY: rsp.ready <= ($urandom_range(0, 3) != 0);
					RX_COMB:   rsp.ready <= (tick % 5 < 2);
					RX_SPARSE: rsp.ready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic wait_drain();
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid <= 1'b1;
		req.payload <= it;
		do @(posedge clk); while (!req.ready);
		sb.note_request(it);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.payload <= '{reg_index: idx, wdata: data};
		do @(posedge clk); while (!cfg.ready);
		sb.set_reg(idx, data);
	endtask

	function automatic in_item_t plot_item(logic [31:0] x, logic [31:0] y);
		in_item_t it;
		it.op = OP_PLOT;
		it.point_x = x;
		it.point_y = y;
		it.word_index = WIDX_W'($urandom_range(0, MAP_WORDS - 1));
		return it;
	endfunction

	function automatic in_item_t read_item(logic [WIDX_W-1:0] w);
		in_item_t it;
		it.op = OP_READ;
		it.point_x = $urandom;
		it.point_y = $urandom;
		it.word_index = w;
		return it;
	endfunction

	// Most plots land near the view centre, scaled so that they cover the tile.
	function automatic in_item_t make_item();
		in_item_t it;
		int unsigned pick;
		longint span, mag, reach;
		it = plot_item($urandom, $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			it.op = OP_READ;
			if (pick < 9 && sb.touched.size() > 0)
				it.word_index = sb.touched[$urandom_range(0, sb.touched.size() - 1)];
		end else if (pick < 30 && recent_pts.size() > 0) begin
			it = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
		end else if (pick >= 40) begin
			mag = (cur_kc < 0 ? -cur_kc : cur_kc) + (cur_ks < 0 ? -cur_ks : cur_ks) + 1;
			reach = (cur_w > cur_h ? cur_w : cur_h) / 2 + 2;
			span = (reach << 32) / mag;
			if (span > (longint'(1) << 30))
				span = longint'(1) << 30;
			if (span < 1)
				span = 1;
			it.point_x = 32'(cur_cx + longint'($urandom_range(0, 32'(2 * span))) - span);
			it.point_y = 32'(cur_cy + longint'($urandom_range(0, 32'(2 * span))) - span);
			recent_pts.push_back(it);
			if (recent_pts.size() > 32)
				void'(recent_pts.pop_front());
		end
		return it;
	endfunction

	task automatic run_phase(input logic [31:0] cx, cy, kc, ks, ox, oy,
			input logic [TDIM_W-1:0] tw, th, input int n, input bit gaps,
			input phase_event_t ev);
		int i;
		req.valid <= 1'b0;
		wait_drain();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_COEFF_COS, kc);
		write_reg(REG_COEFF_SIN, ks);
		write_reg(REG_OFFSET_X, ox);
		write_reg(REG_OFFSET_Y, oy);
		write_reg(REG_TILE_W, 32'(tw));
		write_reg(REG_TILE_H, 32'(th));
		cfg.valid <= 1'b0;
		cur_cx = longint'($signed(cx));
		cur_cy = longint'($signed(cy));
		cur_kc = longint'($signed(kc));
		cur_ks = longint'($signed(ks));
		cur_w = (tw > DEF_MAX_TILE_W) ? DEF_MAX_TILE_W : tw;
		cur_h = (th > DEF_MAX_TILE_H) ? DEF_MAX_TILE_H : th;
		recent_pts.delete();
		sender_gaps = gaps;
		for (i = 0; i < n; i++) begin
			if (i == n / 2 && ev == EV_HOLD)
				rsp_hold_pending = 1'b1;
			if (i == n / 2 && ev == EV_DRAIN) begin
				req.valid <= 1'b0;
				wait_drain();
			end
			send_item(make_item());
		end
	endtask

	initial begin
		int ph;
		int unsigned rw, rh;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.payload = '0;
		cfg.valid = 1'b0;
		cfg.payload = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset view: scale 100, tile spans x from about -20.48 to -10.24 and y from 10.24 to 20.48.
		send_item(plot_item(-32'sd983040, 32'sd983040));
		send_item(plot_item(-32'sd983040, 32'sd983040));
		send_item(read_item(sb.touched[$]));
		send_item(plot_item(-32'sd671089, 32'sd983040));
		send_item(plot_item(-32'sd671088, 32'sd983040));
		send_item(plot_item(-32'sd1342177, 32'sd983040));
		send_item(plot_item(-32'sd1342176, 32'sd983040));
		send_item(plot_item(-32'sd983040, 32'sd671089));
		send_item(plot_item(-32'sd983040, 32'sd671088));
		send_item(plot_item(-32'sd983040, 32'sd1342176));
		send_item(plot_item(32'h7fff_ffff, 32'h8000_0000));
		send_item(plot_item(32'h8000_0000, 32'h7fff_ffff));
		send_item(plot_item(32'h0, 32'h0));
		send_item(plot_item(32'hffff_ffff, 32'hffff_ffff));
		send_item(read_item('0));
		send_item(read_item('1));
		send_item(read_item(14'h2aaa));
		send_item(read_item(14'h1555));
		send_item(read_item(sb.touched[0]));

		run_phase($urandom, $urandom, 32'sd65536, 32'sd0, 32'sd32, 32'sd16,
			11'd64, 11'd32, 120, 1'b1, EV_NONE);
		// Scale 3 at 30 degrees; the result side is held off long enough to back up the input.
		run_phase($urandom, $urandom, 32'sd170268, 32'sd98304, 32'sd512, 32'sd512,
			11'd1024, 11'd1024, 140, 1'b0, EV_HOLD);
		run_phase($urandom, $urandom, 32'sd65536, 32'sd0, 32'sd0, 32'sd0,
			11'd1, 11'd1, 40, 1'b1, EV_NONE);
		// A zero width clips everything.
		run_phase($urandom, $urandom, -32'sd65536, 32'sd4096, 32'sd0, 32'sd350,
			11'd0, 11'd700, 30, 1'b1, EV_NONE);
		// Extreme coefficients and centres; tile sizes above the maximum saturate.
		run_phase(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'sd300, 32'sd200, 11'd2047, 11'd1500, 80, 1'b1, EV_NONE);
		run_phase(32'h0, 32'h0, 32'sd65536000, -32'sd458752, -32'sd8388608,
			32'sd8388607, 11'd1024, 11'd1, 40, 1'b0, EV_NONE);
		for (ph = 0; ph < 2; ph++) begin
			rw = $urandom_range(1, DEF_MAX_TILE_W);
			rh = $urandom_range(1, DEF_MAX_TILE_H);
			run_phase($urandom, $urandom,
				$signed($urandom) >>> $urandom_range(0, 16),
				$signed($urandom) >>> $urandom_range(0, 16),
				32'(rw / 2 + $urandom_range(0, 4) - 2),
				32'(rh / 2 + $urandom_range(0, 4) - 2),
				11'(rw), 11'(rh), 130, ph[0] == 1'b0,
				(ph == 0) ? EV_DRAIN : EV_NONE);
		end

		req.valid <= 1'b0;
		wait_drain();
		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/ppob_pkg.sv
hdl/ppob_stream_if.sv
hdl/ppob_ram.sv
hdl/ppob_ctrl.sv
hdl/ppob_dp.sv
hdl/point_projection_occupancy_bitmap.sv
test/tb_top.sv
